// ----- rtl/lrukv_pkg.sv -----
`default_nettype none
package lrukv_pkg;
   localparam int MaxEntriesDefault = 16;
   localparam int KeyWidth = 32;
   localparam int ValueWidth = 32;
   localparam int CapWidth = 5;
   localparam logic [CapWidth-1:0] CapReset = 5'd16;
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;
   localparam logic [ValueWidth-1:0] MissValue = '1;

   typedef struct packed {
      logic lookup;
      logic update;
   } lrukv_cmd_type;

   typedef struct packed {
      logic hit;
   } lrukv_stat_type;
endpackage
`default_nettype wire

// ----- rtl/lrukv_if.sv -----
`default_nettype none
interface lrukv_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [31:0] key;
   logic [31:0] write_value;
   modport source (output valid, operation, key, write_value, input ready);
   modport sink (input valid, operation, key, write_value, output ready);
endinterface

interface lrukv_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic [31:0] read_value;
   modport source (output valid, found, read_value, input ready);
   modport sink (input valid, found, read_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/lrukv_ctrl.sv -----
`default_nettype none
module lrukv_ctrl
   import lrukv_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output lrukv_cmd_type      cmd
);
   typedef enum logic [0:0] {S_IDLE, S_UPDATE} state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // lookup: capture beat; update: commit state and load result register
   // hold the update while the result register is still offered
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.lookup = 1'b0;
      cmd.update = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.lookup = 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.update = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/lrukv_dp.sv -----
`default_nettype none
module lrukv_dp
   import lrukv_pkg::*;
#(
   parameter int MAX_ENTRIES = MaxEntriesDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CapWidth-1:0]   capacity,
   input  lrukv_cmd_type              cmd,
   input  wire logic                  operation,
   input  wire logic [KeyWidth-1:0]   key,
   input  wire logic [ValueWidth-1:0] write_value,
   output logic                       found,
   output logic [ValueWidth-1:0]      read_value,
   output lrukv_stat_type             stat
);
   localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CntW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = (CntW > CapWidth) ? CntW : CapWidth;

   logic [KeyWidth-1:0]   keys_ff [MAX_ENTRIES];
   logic [ValueWidth-1:0] vals_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [IdxW-1:0]       rank_ff [MAX_ENTRIES];
   logic [CntW-1:0]       count_ff;

   logic                  op_ff;
   logic [KeyWidth-1:0]   key_ff;
   logic [ValueWidth-1:0] wval_ff;
   logic                  hit_ff;
   logic [IdxW-1:0]       hidx_ff;
   logic [ValueWidth-1:0] hval_ff;
   logic [IdxW-1:0]       hrank_ff;
   logic                  full_ff;
   logic [IdxW-1:0]       victim_ff;
   logic                  vany_ff;
   logic [IdxW-1:0]       free_ff;

   logic                  hit_in;
   logic [IdxW-1:0]       hidx_in;
   logic                  vany_in;
   logic [IdxW-1:0]       victim_in;
   logic                  fany_in;
   logic [IdxW-1:0]       free_in;
   logic [CW-1:0]         effcap;

   // parallel match; victim is the entry whose rank is count-1
   always_comb begin
      hit_in = 1'b0;
      hidx_in = '0;
      vany_in = 1'b0;
      victim_in = '0;
      fany_in = 1'b0;
      free_in = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && keys_ff[i] == key) begin
            hit_in = 1'b1;
            hidx_in = IdxW'(i);
         end
         if (valid_ff[i] && CntW'(rank_ff[i]) == count_ff - CntW'(1)) begin
            vany_in = 1'b1;
            victim_in = IdxW'(i);
         end
         if (!valid_ff[i]) begin
            fany_in = 1'b1;
            free_in = IdxW'(i);
         end
      end
      effcap = CW'(capacity);
      if (effcap == '0) effcap = CW'(1);
      if (effcap > CW'(MAX_ENTRIES)) effcap = CW'(MAX_ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         op_ff <= operation;
         key_ff <= key;
         wval_ff <= write_value;
         hit_ff <= hit_in;
         hidx_ff <= hidx_in;
         hval_ff <= vals_ff[hidx_in];
         hrank_ff <= rank_ff[hidx_in];
         full_ff <= CW'(count_ff) >= effcap;
         vany_ff <= vany_in;
         victim_ff <= victim_in;
         free_ff <= fany_in ? free_in : victim_in;
      end
   end

   logic evict;
   logic [IdxW-1:0] slot;
   logic [CntW-1:0] count_in;
   logic [MAX_ENTRIES-1:0] valid_in;
   assign evict = full_ff && vany_ff;
   // when full and evicting, lowest free slot may be the victim itself
   always_comb begin
      slot = free_ff;
      if (evict) begin
         slot = victim_ff;
         for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_ff[i] || IdxW'(i) == victim_ff) slot = IdxW'(i);
         end
      end
      count_in = count_ff;
      if (!evict && !(count_ff == CntW'(MAX_ENTRIES))) count_in = count_ff + CntW'(1);
      valid_in = valid_ff;
      if (evict) valid_in[victim_ff] = 1'b0;
      valid_in[slot] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) rank_ff[i] <= '0;
      end else if (cmd.update) begin
         if (hit_ff) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (IdxW'(i) == hidx_ff) rank_ff[i] <= '0;
               else if (valid_ff[i] && rank_ff[i] < hrank_ff)
                  rank_ff[i] <= rank_ff[i] + IdxW'(1);
            end
            if (op_ff == OP_PUT) vals_ff[hidx_ff] <= wval_ff;
         end else if (op_ff == OP_PUT) begin
            if (evict || count_ff != CntW'(MAX_ENTRIES)) begin
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (IdxW'(i) == slot) rank_ff[i] <= '0;
                  else if (valid_ff[i] && !(evict && IdxW'(i) == victim_ff))
                     rank_ff[i] <= rank_ff[i] + IdxW'(1);
               end
               keys_ff[slot] <= key_ff;
               vals_ff[slot] <= wval_ff;
               valid_ff <= valid_in;
               count_ff <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         found <= hit_ff;
         if (op_ff == OP_PUT) read_value <= '0;
         else if (hit_ff) read_value <= hval_ff;
         else read_value <= MissValue;
      end
   end

   assign stat.hit = hit_ff;
endmodule
`default_nettype wire

// ----- rtl/lru_key_value_cache_top.sv -----
// Request flow: a lookup state captures the beat, then an update state loads the
// response register; a new request is taken only once back in idle, and a held
// response stalls the update and with it the next request.
// Reset: synchronous, clears valid bits, ranks, occupancy; capacity to 16.
`default_nettype none
module lru_key_value_cache_top
   import lrukv_pkg::*;
#(
   parameter int MAX_ENTRIES = MaxEntriesDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   lrukv_req_if.sink                req,
   lrukv_rsp_if.source              rsp,
   input  wire logic                csr_write_enable,
   input  wire logic [CapWidth-1:0] csr_write_data
);
   logic [CapWidth-1:0] capacity_ff;
   lrukv_cmd_type cmd;
   lrukv_stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= CapReset;
      else if (csr_write_enable) capacity_ff <= csr_write_data;
   end

   lrukv_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd)
   );

   lrukv_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .capacity(capacity_ff), .cmd(cmd),
      .operation(req.operation), .key(req.key), .write_value(req.write_value),
      .found(rsp.found), .read_value(rsp.read_value), .stat(stat)
   );

`ifndef SYNTHESIS
   a_update_gated: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> !(rsp.valid && !rsp.ready)) else $error("update over held response");
   a_update_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp.valid) else $error("update not followed by response");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.found)
      && $stable(rsp.read_value)) else $error("response changed while held");
   a_hit_found: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp.found == $past(stat.hit)) else $error("found mismatch");
`endif
endmodule
`default_nettype wire

// ----- tb/tb_lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
module tb_lru_key_value_cache_top
   import lrukv_pkg::*;
;

   class lru_scoreboard;
      logic [31:0] keys [16];
      logic [31:0] vals [16];
      bit          valid [16];
      int unsigned rank [16];
      int unsigned occupied;
      logic [4:0]  cap;
      logic        exp_found [$];
      logic [31:0] exp_value [$];
      int          mismatches;

      function new();
         for (int i = 0; i < 16; i++) begin
            valid[i] = 0;
            rank[i] = 0;
         end
         occupied = 0;
         cap = CapReset;
         mismatches = 0;
      endfunction

      function void set_capacity(logic [4:0] c);
         cap = c;
      endfunction

      function void promote(int idx);
         for (int i = 0; i < 16; i++)
            if (valid[i] && rank[i] < rank[idx]) rank[i]++;
         rank[idx] = 0;
      endfunction

      function void note_request(logic op, logic [31:0] k, logic [31:0] v);
         int hit_idx;
         int eff;
         int victim;
         int slot;
         hit_idx = -1;
         for (int i = 0; i < 16; i++)
            if (hit_idx < 0 && valid[i] && keys[i] == k) hit_idx = i;
         if (op == OP_GET) begin
            if (hit_idx >= 0) begin
               promote(hit_idx);
               exp_found.push_back(1'b1);
               exp_value.push_back(vals[hit_idx]);
            end else begin
               exp_found.push_back(1'b0);
               exp_value.push_back(MissValue);
            end
            return;
         end
         exp_found.push_back(hit_idx >= 0);
         exp_value.push_back('0);
         if (hit_idx >= 0) begin
            vals[hit_idx] = v;
            promote(hit_idx);
            return;
         end
         eff = (cap == 0) ? 1 : (cap > 16) ? 16 : cap;
         if (occupied >= eff) begin
            victim = -1;
            for (int i = 0; i < 16; i++)
               if (valid[i] && (victim < 0 || rank[i] > rank[victim])) victim = i;
            if (victim >= 0) begin
               valid[victim] = 0;
               rank[victim] = 0;
               occupied--;
            end
         end
         slot = -1;
         for (int i = 0; i < 16; i++)
            if (slot < 0 && !valid[i]) slot = i;
         if (slot < 0) return;
         for (int i = 0; i < 16; i++)
            if (valid[i]) rank[i]++;
         keys[slot] = k;
         vals[slot] = v;
         valid[slot] = 1;
         rank[slot] = 0;
         occupied++;
      endfunction

      function void check_response(logic f, logic [31:0] v);
         logic ef;
         logic [31:0] ev;
         if (exp_found.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response found=%0b value=%h", f, v);
            return;
         end
         ef = exp_found.pop_front();
         ev = exp_value.pop_front();
         if (f !== ef || v !== ev) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected found=%0b value=%h, got found=%0b value=%h",
                        ef, ev, f, v);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [4:0] csr_write_data;

   lrukv_req_if req_if ();
   lrukv_rsp_if rsp_if ();

   lru_key_value_cache_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lru_scoreboard sb;
   int  idle_cycles;
   bit  hold_rsp;
   logic [31:0] key_pool [8];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      sb = new();
      reset = 1;
      csr_write_enable = 0;
      csr_write_data = '0;
      req_if.valid = 0;
      req_if.operation = OP_GET;
      req_if.key = '0;
      req_if.write_value = '0;
      rsp_if.ready = 0;
      hold_rsp = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      if (req_if.valid && req_if.ready || rsp_if.valid && rsp_if.ready || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.found, rsp_if.read_value);

   initial begin
      int wait_n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 0;
         end else if (rsp_if.ready && rsp_if.valid || !rsp_if.ready) begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 1)) wait_n = 0;
            if (wait_n == 0) begin
               rsp_if.ready <= 1;
            end else begin
               rsp_if.ready <= 0;
               repeat (wait_n) @(posedge clock);
               rsp_if.ready <= 1;
            end
         end
      end
   end

   task automatic send_beat(logic op, logic [31:0] k, logic [31:0] v, int gap);
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.operation <= op;
      req_if.key <= k;
      req_if.write_value <= v;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(op, k, v);
   endtask

   task automatic drain();
      req_if.valid <= 0;
      while (sb.exp_found.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] c);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= c;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.set_capacity(c);
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 9) < 8) return key_pool[3'($urandom_range(0, 7))];
      return $urandom;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 1)) return 0;
      return $urandom_range(0, 15);
   endfunction

   initial begin
      logic [4:0] caps [6];
      caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17};
      @(negedge reset);
      @(posedge clock);
      send_beat(OP_GET, 32'h8000_0000, 32'h0, 0);
      send_beat(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_beat(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_beat(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_beat(OP_PUT, 32'h0, 32'h0, 0);
      send_beat(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 0);
      send_beat(OP_GET, 32'hFFFF_FFFF, 32'h0, 0);
      send_beat(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678, 0);
      send_beat(OP_GET, 32'h7FFF_FFFF, 32'h0, 0);
      for (int i = 0; i < 18; i++) send_beat(OP_PUT, i + 100, i, 0);
      send_beat(OP_GET, 32'd100, 32'h0, 0);
      write_capacity(5'd2);
      send_beat(OP_PUT, 32'd500, 32'd5, 0);
      send_beat(OP_GET, 32'd117, 32'h0, 0);
      for (int ph = 0; ph < 6; ph++) begin
         write_capacity(caps[ph]);
         for (int j = 0; j < 8; j++) key_pool[j] = $urandom;
         for (int n = 0; n < 320; n++) begin
            if ($urandom_range(0, 15) == 0) key_pool[3'($urandom_range(0, 7))] = $urandom;
            send_beat(1'($urandom_range(0, 1)), pick_key(), $urandom, pick_gap());
            if (ph == 1 && n == 40) begin
               hold_rsp = 1;
               fork
                  begin
                     repeat (200) @(posedge clock);
                     hold_rsp = 0;
                  end
               join_none
            end
            if (ph == 2 && n == 60) drain();
         end
      end
      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.exp_found.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ----- lru_key_value_cache_top.f -----
rtl/lrukv_pkg.sv
rtl/lrukv_if.sv
rtl/lrukv_ctrl.sv
rtl/lrukv_dp.sv
rtl/lru_key_value_cache_top.sv
tb/tb_lru_key_value_cache_top.sv
